>>> rtl/core/nested_comment_layout_skipper_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the layout skipper
// Shared helpers for concurrent checks clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NESTED_COMMENT_LAYOUT_SKIPPER_MACROS_SVH
`define NESTED_COMMENT_LAYOUT_SKIPPER_MACROS_SVH

// Check that a condition implies another in the same cycle
`define NCLS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle
`define NCLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ncls_pkg.sv
// ----------------------------------------------------------------------------
// ncls_pkg
// Types and constants shared by the layout skipper modules.
// ----------------------------------------------------------------------------
package ncls_pkg;

    // Stream widths
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 1;

    // Block comment nesting limit
    localparam int MAX_NEST = 255;
    localparam int NEST_W   = $clog2(MAX_NEST + 1);

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_SLASH = 8'd47;

    // Scanner modes
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_LAYOUT = 3'd1,
        MODE_SLASH  = 3'd2,
        MODE_LINE   = 3'd3,
        MODE_BLOCK  = 3'd4,
        MODE_BSTAR  = 3'd5,
        MODE_BSLASH = 3'd6
    } mode_t;

    // One input item
    typedef struct packed {
        logic        start_req;
        logic        base_known;
        logic [31:0] line_in;
        logic [7:0]  ch;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic [15:0] token_offset;
        logic [31:0] line_out;
        logic [15:0] column;
        logic        column_valid;
    } res_t;

endpackage

>>> rtl/core/ncls_in_reg.sv
// ----------------------------------------------------------------------------
// ncls_in_reg
// Input register: captures one item from the slave stream and holds it
// until the scanner consumes it.
// ----------------------------------------------------------------------------
module ncls_in_reg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ncls_pkg::IN_DATA_W-1:0] s_tdata,  // line_in, ch
    input  logic [ncls_pkg::IN_USER_W-1:0] s_tuser,  // start_req, base_known
    input  logic                           take,
    output logic                           in_valid,
    output ncls_pkg::in_item_t             in_item
);
    import ncls_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    // Accept when empty or when the held item leaves this cycle
    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.start_req  <= s_tuser[0];
            item_reg.base_known <= s_tuser[1];
            item_reg.line_in    <= s_tdata[31:0];
            item_reg.ch         <= s_tdata[39:32];
        end
    end

    assign in_valid = valid_reg;
    assign in_item  = item_reg;

endmodule

>>> rtl/core/ncls_scan.sv
// ----------------------------------------------------------------------------
// ncls_scan
// Scanner: one step per item of the layout and comment state machine,
// with saturating offset, column and nesting counters.
// ----------------------------------------------------------------------------
module ncls_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  ncls_pkg::in_item_t in_item,
    input  logic               out_free,
    output logic               fire,
    output logic               res_valid,
    output ncls_pkg::res_t     res
);
    import ncls_pkg::*;

    mode_t              mode_reg,  mode_next,  mode_e;
    logic [NEST_W-1:0]  depth_reg, depth_next, depth_e;
    logic [15:0]        skip_reg,  skip_next,  skip_e;
    logic [31:0]        line_reg,  line_next,  line_e;
    logic [15:0]        col_reg,   col_next,   col_e;
    logic               known_reg, known_next, known_e;
    logic               done;
    logic [7:0]         c;

    // Saturating add of a small step to a 16-bit count
    function automatic logic [15:0] sat_add(input logic [15:0] v, input logic [1:0] inc);
        logic [16:0] s;
        s = {1'b0, v} + {15'b0, inc};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_TAB) || (b == CH_VT) || (b == CH_FF) ||
               (b == CH_CR) || (b == CH_SPACE);
    endfunction

    assign c = in_item.ch;

    // Apply a new request on top of the held state
    always_comb
    begin
        mode_e  = mode_reg;
        depth_e = depth_reg;
        skip_e  = skip_reg;
        line_e  = line_reg;
        col_e   = col_reg;
        known_e = known_reg;
        if (in_item.start_req)
        begin
            mode_e  = MODE_LAYOUT;
            depth_e = '0;
            skip_e  = '0;
            line_e  = in_item.line_in;
            col_e   = '0;
            known_e = in_item.base_known;
        end
    end

    // Next state for one byte
    always_comb
    begin
        mode_next  = mode_e;
        depth_next = depth_e;
        skip_next  = skip_e;
        line_next  = line_e;
        col_next   = col_e;
        known_next = known_e;
        done       = 1'b0;
        case (mode_e)
            MODE_LAYOUT:
            begin
                if (c == CH_NUL)
                begin
                    done = 1'b1;
                end
                else if (is_blank(c))
                begin
                    skip_next = sat_add(skip_e, 2'd1);
                    col_next  = sat_add(col_e, 2'd1);
                end
                else if (c == CH_NL)
                begin
                    skip_next  = sat_add(skip_e, 2'd1);
                    line_next  = line_e + 32'd1;
                    col_next   = '0;
                    known_next = 1'b1;
                end
                else if (c == CH_SLASH)
                begin
                    mode_next = MODE_SLASH;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            MODE_SLASH:
            begin
                // Consume the slash and its partner as a pair
                if (c == CH_SLASH)
                begin
                    skip_next = sat_add(skip_e, 2'd2);
                    col_next  = sat_add(col_e, 2'd2);
                    mode_next = MODE_LINE;
                end
                else if (c == CH_STAR)
                begin
                    skip_next  = sat_add(skip_e, 2'd2);
                    col_next   = sat_add(col_e, 2'd2);
                    depth_next = NEST_W'(1);
                    mode_next  = MODE_BLOCK;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            MODE_LINE:
            begin
                if (c == CH_NUL)
                begin
                    done = 1'b1;
                end
                else if (c == CH_NL)
                begin
                    skip_next  = sat_add(skip_e, 2'd1);
                    line_next  = line_e + 32'd1;
                    col_next   = '0;
                    known_next = 1'b1;
                    mode_next  = MODE_LAYOUT;
                end
                else
                begin
                    skip_next = sat_add(skip_e, 2'd1);
                    col_next  = sat_add(col_e, 2'd1);
                end
            end
            MODE_BLOCK, MODE_BSTAR, MODE_BSLASH:
            begin
                if (c == CH_NUL)
                begin
                    done = 1'b1;
                end
                else if (c == CH_NL)
                begin
                    skip_next  = sat_add(skip_e, 2'd1);
                    line_next  = line_e + 32'd1;
                    col_next   = '0;
                    known_next = 1'b1;
                    mode_next  = MODE_BLOCK;
                end
                else
                begin
                    skip_next = sat_add(skip_e, 2'd1);
                    col_next  = sat_add(col_e, 2'd1);
                    if ((mode_e == MODE_BSTAR) && (c == CH_SLASH))
                    begin
                        // Close one level
                        if (depth_e != '0)
                        begin
                            depth_next = depth_e - NEST_W'(1);
                        end
                        mode_next = (depth_next == '0) ? MODE_LAYOUT : MODE_BLOCK;
                    end
                    else if ((mode_e == MODE_BSLASH) && (c == CH_STAR))
                    begin
                        // Open one level, saturating at the limit
                        if (depth_e < NEST_W'(MAX_NEST))
                        begin
                            depth_next = depth_e + NEST_W'(1);
                        end
                        mode_next = MODE_BLOCK;
                    end
                    else if (c == CH_STAR)
                    begin
                        mode_next = MODE_BSTAR;
                    end
                    else if (c == CH_SLASH)
                    begin
                        mode_next = MODE_BSLASH;
                    end
                    else
                    begin
                        mode_next = MODE_BLOCK;
                    end
                end
            end
            default:
            begin
                // Idle bytes are dropped
                mode_next = MODE_IDLE;
            end
        endcase
        if (done)
        begin
            mode_next = MODE_IDLE;
        end
    end

    // Step outputs: advance unless a result has nowhere to go
    always_comb
    begin
        fire             = in_valid && (!done || out_free);
        res_valid        = fire && done;
        res.token_offset = skip_e;
        res.line_out     = line_e;
        res.column       = known_e ? col_e : 16'd0;
        res.column_valid = known_e;
    end

    // Scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            depth_reg <= '0;
            skip_reg  <= '0;
            line_reg  <= '0;
            col_reg   <= '0;
            known_reg <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            depth_reg <= depth_next;
            skip_reg  <= skip_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            known_reg <= known_next;
        end
    end

endmodule

>>> rtl/core/ncls_out_reg.sv
// ----------------------------------------------------------------------------
// ncls_out_reg
// Result register: holds one result item on the master stream until the
// receiver takes it.
// ----------------------------------------------------------------------------
module ncls_out_reg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            res_valid,
    input  ncls_pkg::res_t                  res,
    output logic                            out_free,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ncls_pkg::OUT_DATA_W-1:0] m_tdata,  // token_offset, line_out, column
    output logic [ncls_pkg::OUT_USER_W-1:0] m_tuser   // column_valid
);
    import ncls_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    // Room for a new result when empty or being drained
    assign out_free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the result
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.column, res_reg.line_out, res_reg.token_offset};
    assign m_tuser  = res_reg.column_valid;

endmodule

>>> rtl/core/nested_comment_layout_skipper.sv
// ----------------------------------------------------------------------------
// nested_comment_layout_skipper
// Skips layout, line comments and nested block comments ahead of a lexer.
// ----------------------------------------------------------------------------
// Usage:
//   Text bytes enter on the s_ stream, one per item. An item with start_req
//   set opens a new skip request and loads line_in and base_known; a request
//   in progress is dropped without a result. Bytes outside a request are
//   ignored.
//   When the first token byte, a lone slash or a zero byte is reached, one
//   result (offset, line, column, column-valid) leaves on the m_ stream.
//   Path: the item that ends the skip passes the input register, the scanner
//   step and then the result register before its result shows on m_tvalid.
//   Throughput: one item per cycle except in the stall below; a single step of
//   logic updates the scanner state between the input and result registers.
//   Stall: while a result waits on m_tready, items that produce no result
//   keep flowing; an item that would produce a second result holds in the
//   input register, and s_tready drops only then.
//   Reset: both registers empty, scanner idle with all counters zero.
// ----------------------------------------------------------------------------
`include "nested_comment_layout_skipper_macros.svh"

module nested_comment_layout_skipper (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ncls_pkg::IN_DATA_W-1:0]  s_tdata,  // line_in[31:0], ch[39:32]
    input  logic [ncls_pkg::IN_USER_W-1:0]  s_tuser,  // start_req[0], base_known[1]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ncls_pkg::OUT_DATA_W-1:0] m_tdata,  // token_offset[15:0],
                                                      // line_out[47:16], column[63:48]
    output logic [ncls_pkg::OUT_USER_W-1:0] m_tuser   // column_valid[0]
);
    import ncls_pkg::*;

    logic     in_valid;
    in_item_t in_item;
    logic     fire;
    logic     out_free;
    logic     res_valid;
    res_t     res;

    // Input register
    ncls_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .take     (fire),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    // Scanner step
    ncls_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .out_free  (out_free),
        .fire      (fire),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register
    ncls_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // A result is only produced when the result register has room
    `NCLS_ASSERT_SAME(a_res_has_room, res_valid, out_free, "result produced while output full")
    // A held item that cannot advance must block the input
    `NCLS_ASSERT_SAME(a_block_on_hold, in_valid && !fire, !s_tready, "input taken while item held")
    // An accepted item lands in the input register
    `NCLS_ASSERT_NEXT(a_item_lands, s_tvalid && s_tready, in_valid, "accepted item lost")
    // Unknown column is reported as zero
    `NCLS_ASSERT_SAME(a_col_zero, m_tvalid && !m_tuser[0], m_tdata[63:48] == 16'd0,
        "column nonzero while not valid")

endmodule

>>> sim/layout_skip_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// layout_skip_checker
// Watches both streams of the layout skipper, predicts the token location
// from every accepted text byte and compares each result item field by field.
// ----------------------------------------------------------------------------
module layout_skip_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [ncls_pkg::IN_DATA_W-1:0]  s_tdata,  // line_in[31:0], ch[39:32]
    input  logic [ncls_pkg::IN_USER_W-1:0]  s_tuser,  // start_req[0], base_known[1]
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ncls_pkg::OUT_DATA_W-1:0] m_tdata,  // token_offset[15:0],
                                                      // line_out[47:16], column[63:48]
    input  logic [ncls_pkg::OUT_USER_W-1:0] m_tuser,  // column_valid[0]
    output int                              errors,
    output int                              pending,
    output int                              results_seen
);
    import ncls_pkg::*;

    // Predicted scanner state
    mode_t             mode_q;
    logic [NEST_W-1:0] depth_q;
    logic [15:0]       offset_q;
    logic [31:0]       line_q;
    logic [15:0]       col_q;
    logic              col_known_q;

    // Token locations still owed by the block, oldest first
    res_t     token_q[$];
    in_item_t seen_item;
    res_t     got_res;
    res_t     want_res;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR || c == CH_SPACE;
    endfunction

    task consume_byte();
        offset_q = sat_inc(offset_q);
        col_q    = sat_inc(col_q);
    endtask

    task consume_newline();
        offset_q    = sat_inc(offset_q);
        line_q      = line_q + 32'd1;
        col_q       = 16'd0;
        col_known_q = 1'b1;
    endtask

    // Record the token location and go idle
    task emit_token();
        res_t r;
        r.token_offset = offset_q;
        r.line_out     = line_q;
        r.column       = col_known_q ? col_q : 16'd0;
        r.column_valid = col_known_q;
        token_q.push_back(r);
        mode_q = MODE_IDLE;
    endtask

    // Advance the predicted scanner by one text byte
    task scan_byte(input in_item_t it);
        logic [7:0] c;
        c = it.ch;
        if (it.start_req) begin
            mode_q      = MODE_LAYOUT;
            depth_q     = '0;
            offset_q    = 16'd0;
            col_q       = 16'd0;
            line_q      = it.line_in;
            col_known_q = it.base_known;
        end
        case (mode_q)
            MODE_LAYOUT: begin
                if (c == CH_NUL)
                    emit_token();
                else if (is_blank(c))
                    consume_byte();
                else if (c == CH_NL)
                    consume_newline();
                else if (c == CH_SLASH)
                    mode_q = MODE_SLASH;
                else
                    emit_token();
            end
            MODE_SLASH: begin
                if (c == CH_SLASH) begin
                    consume_byte();
                    consume_byte();
                    mode_q = MODE_LINE;
                end
                else if (c == CH_STAR) begin
                    consume_byte();
                    consume_byte();
                    depth_q = NEST_W'(1);
                    mode_q  = MODE_BLOCK;
                end
                else begin
                    // lone slash: the token starts at the slash
                    emit_token();
                end
            end
            MODE_LINE: begin
                if (c == CH_NUL)
                    emit_token();
                else if (c == CH_NL) begin
                    consume_newline();
                    mode_q = MODE_LAYOUT;
                end
                else
                    consume_byte();
            end
            MODE_BLOCK, MODE_BSTAR, MODE_BSLASH: begin
                if (c == CH_NUL)
                    emit_token();
                else if (c == CH_NL) begin
                    consume_newline();
                    mode_q = MODE_BLOCK;
                end
                else begin
                    consume_byte();
                    if (mode_q == MODE_BSTAR && c == CH_SLASH) begin
                        if (depth_q != '0)
                            depth_q = depth_q - NEST_W'(1);
                        mode_q = (depth_q == '0) ? MODE_LAYOUT : MODE_BLOCK;
                    end
                    else if (mode_q == MODE_BSLASH && c == CH_STAR) begin
                        // depth holds at the nesting limit
                        if (depth_q < NEST_W'(MAX_NEST))
                            depth_q = depth_q + NEST_W'(1);
                        mode_q = MODE_BLOCK;
                    end
                    else if (c == CH_STAR)
                        mode_q = MODE_BSTAR;
                    else if (c == CH_SLASH)
                        mode_q = MODE_BSLASH;
                    else
                        mode_q = MODE_BLOCK;
                end
            end
            default: mode_q = MODE_IDLE;
        endcase
    endtask

    // Check results first, then predict from the accepted byte
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_q       = MODE_IDLE;
            depth_q      = '0;
            offset_q     = 16'd0;
            line_q       = 32'd0;
            col_q        = 16'd0;
            col_known_q  = 1'b0;
            token_q.delete();
            errors       = 0;
            results_seen = 0;
            pending     <= 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                got_res.token_offset = m_tdata[15:0];
                got_res.line_out     = m_tdata[47:16];
                got_res.column       = m_tdata[63:48];
                got_res.column_valid = m_tuser[0];
                if (token_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result offset %0d line %0d column %0d valid %0b",
                                 $realtime, got_res.token_offset, got_res.line_out,
                                 got_res.column, got_res.column_valid);
                end
                else begin
                    want_res = token_q.pop_front();
                    if (got_res.token_offset !== want_res.token_offset ||
                        got_res.line_out     !== want_res.line_out     ||
                        got_res.column       !== want_res.column       ||
                        got_res.column_valid !== want_res.column_valid) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: mismatch on result %0d", $realtime, results_seen);
                            $display("  expected offset %0d line %0d column %0d valid %0b",
                                     want_res.token_offset, want_res.line_out,
                                     want_res.column, want_res.column_valid);
                            $display("  actual   offset %0d line %0d column %0d valid %0b",
                                     got_res.token_offset, got_res.line_out,
                                     got_res.column, got_res.column_valid);
                        end
                    end
                end
                results_seen++;
            end
            if (s_tvalid && s_tready) begin
                seen_item.start_req  = s_tuser[0];
                seen_item.base_known = s_tuser[1];
                seen_item.line_in    = s_tdata[31:0];
                seen_item.ch         = s_tdata[39:32];
                scan_byte(seen_item);
            end
            pending <= token_q.size();
        end
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the nested comment layout skipper. Drives skip
// requests built from layout, line comments and nested block comments under
// several source and sink idling mixes; the checker beside the block does
// the prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
    import ncls_pkg::*;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;  // line_in[31:0], ch[39:32]
    logic [IN_USER_W-1:0]  s_tuser  = '0;  // start_req[0], base_known[1]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // token_offset[15:0], line_out[47:16],
                                           // column[63:48]
    logic [OUT_USER_W-1:0] m_tuser;        // column_valid[0]

    int chk_errors;
    int chk_pending;
    int chk_results;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int sink_hold_req = 0;
    int items_sent    = 0;
    int random_items  = 0;

    logic [7:0] text_q[$];

    nested_comment_layout_skipper u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    layout_skip_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .errors       (chk_errors),
        .pending      (chk_pending),
        .results_seen (chk_results)
    );

    // Clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Sink: random back-pressure, plus a long hold when requested
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (sink_hold_req > 0) begin
                hold_left     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0:       return CH_TAB;
            1:       return CH_VT;
            2:       return CH_FF;
            3:       return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    // A byte that starts a token in layout
    function automatic logic [7:0] pick_token();
        logic [7:0] c;
        c = 8'($urandom_range(33, 255));
        if (c == CH_SLASH)
            c = 8'h01;
        return c;
    endfunction

    function automatic logic [7:0] pick_comment_byte();
        case ($urandom_range(0, 11))
            0:       return CH_STAR;
            1:       return CH_SLASH;
            2:       return CH_NL;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Offer one item, idling first at the current source rate
    task send_item(input logic start, input logic known, input logic [31:0] line,
                   input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c, line};
        s_tuser  <= {known, start};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // Stop offering and wait until every owed result has arrived
    task drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (chk_pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // One skip request: layout and comments, then a terminator; now and then noise
    task send_skip_run();
        int         elems;
        int         lvl;
        int         steps;
        int         n;
        logic [7:0] c;
        logic [31:0] line;
        text_q.delete();
        if ($urandom_range(0, 9) == 0) begin
            // noise: random bytes with random starts
            n = $urandom_range(1, 8);
            repeat (n)
                send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                          8'($urandom_range(0, 255)));
            random_items += n;
            return;
        end
        elems = $urandom_range(0, 6);
        repeat (elems) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: text_q.push_back(pick_blank());
                4, 5:       text_q.push_back(CH_NL);
                6, 7: begin
                    text_q.push_back(CH_SLASH);
                    text_q.push_back(CH_SLASH);
                    n = $urandom_range(0, 6);
                    repeat (n) begin
                        c = 8'($urandom_range(1, 255));
                        text_q.push_back((c == CH_NL) ? CH_SPACE : c);
                    end
                    text_q.push_back(CH_NL);
                end
                default: begin
                    // nested block comment, closed level by level
                    text_q.push_back(CH_SLASH);
                    text_q.push_back(CH_STAR);
                    lvl   = 1;
                    steps = $urandom_range(0, 12);
                    for (int s = 0; s < steps && lvl > 0; s++) begin
                        n = $urandom_range(0, 9);
                        if (n < 2 && lvl < 6) begin
                            text_q.push_back(CH_SLASH);
                            text_q.push_back(CH_STAR);
                            lvl++;
                        end
                        else if (n < 4) begin
                            text_q.push_back(CH_STAR);
                            text_q.push_back(CH_SLASH);
                            lvl--;
                        end
                        else
                            text_q.push_back(pick_comment_byte());
                    end
                    while (lvl > 0) begin
                        text_q.push_back(CH_STAR);
                        text_q.push_back(CH_SLASH);
                        lvl--;
                    end
                end
            endcase
        end
        case ($urandom_range(0, 19))
            12, 13, 14: text_q.push_back(CH_NUL);
            15, 16, 17: begin
                // lone slash, followed by a byte that opens no comment
                text_q.push_back(CH_SLASH);
                c = 8'($urandom_range(0, 255));
                text_q.push_back((c == CH_SLASH || c == CH_STAR) ? CH_NUL : c);
            end
            18, 19: begin
                // comment left open until end of text
                text_q.push_back(CH_SLASH);
                text_q.push_back($urandom_range(0, 1) ? CH_STAR : CH_SLASH);
                n = $urandom_range(0, 4);
                repeat (n) text_q.push_back(pick_comment_byte());
                text_q.push_back(CH_NUL);
            end
            default: text_q.push_back(pick_token());
        endcase
        line = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3) : $urandom;
        foreach (text_q[i]) begin
            if (i == 0)
                send_item(1'b1, 1'($urandom_range(0, 1)), line, text_q[i]);
            else
                send_item($urandom_range(0, 49) == 0, 1'($urandom_range(0, 1)), $urandom,
                          text_q[i]);
        end
        random_items += text_q.size();
    endtask

    // Stimulus
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // heavy sink idling
        send_idle_pct = 34;
        recv_idle_pct = 84;

        // byte while idle is ignored
        send_item(1'b0, 1'b0, 32'd0, "q");
        // token right away, top byte value
        send_item(1'b1, 1'b1, 32'd0, 8'hFF);
        // every blank, newline wrapping the line, then a lone slash
        send_item(1'b1, 1'b0, 32'hFFFF_FFFF, CH_TAB);
        send_item(1'b0, 1'b0, 32'd0, CH_VT);
        send_item(1'b0, 1'b0, 32'd0, CH_FF);
        send_item(1'b0, 1'b0, 32'd0, CH_CR);
        send_item(1'b0, 1'b0, 32'd0, CH_SPACE);
        send_item(1'b0, 1'b0, 32'd0, CH_NL);
        send_item(1'b0, 1'b0, 32'd0, CH_SLASH);
        send_item(1'b0, 1'b0, 32'd0, "x");
        // end of text inside a line comment
        send_item(1'b1, 1'b1, 32'd5, CH_SLASH);
        send_item(1'b0, 1'b0, 32'd0, CH_SLASH);
        send_item(1'b0, 1'b0, 32'd0, "c");
        send_item(1'b0, 1'b0, 32'd0, CH_NUL);
        // nested block comment: opening pair bytes start no close
        send_item(1'b1, 1'b0, 32'd77, CH_SLASH);
        send_item(1'b0, 1'b0, 32'd0, CH_STAR);
        send_item(1'b0, 1'b0, 32'd0, CH_SLASH);
        send_item(1'b0, 1'b0, 32'd0, CH_STAR);
        send_item(1'b0, 1'b0, 32'd0, CH_STAR);
        send_item(1'b0, 1'b0, 32'd0, CH_SLASH);
        send_item(1'b0, 1'b0, 32'd0, CH_STAR);
        send_item(1'b0, 1'b0, 32'd0, CH_SLASH);
        send_item(1'b0, 1'b0, 32'd0, "A");
        // restart mid-request, then a slash ended by end of text
        send_item(1'b1, 1'b1, 32'd9, CH_SLASH);
        send_item(1'b1, 1'b1, 32'd3, CH_SPACE);
        send_item(1'b0, 1'b0, 32'd0, CH_SLASH);
        send_item(1'b0, 1'b0, 32'd0, CH_NUL);
        // end of text as the very first byte
        send_item(1'b1, 1'b1, 32'd1, CH_NUL);

        while (random_items < 200)
            send_skip_run();
        drain();

        // heavy source idling
        send_idle_pct = 84;
        recv_idle_pct = 34;
        while (random_items < 400)
            send_skip_run();
        drain();

        // no idling; first hold the sink so the block backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sink_hold_req = 400;
        repeat (40) begin
            send_item(1'b1, 1'($urandom_range(0, 1)), $urandom, CH_SPACE);
            send_item(1'b0, 1'b0, 32'd0, pick_token());
        end
        drain();

        while (random_items < 590)
            send_skip_run();
        drain();
        repeat (8) @(posedge clk);

        $display("Run covered %0d items and %0d results: blanks, newlines, line and", items_sent,
                 chk_results);
        $display("nested block comments, lone slashes, end of text, restarts, line wrap, "
                 , "long sink stalls.");
        if (chk_errors == 0 && chk_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
